// ----- hw/rtl/gfba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gfba_pkg;

  // Fixed field widths
  localparam int BLK_W   = 10;
  localparam int BLK_IDS = 1 << BLK_W;

  // Defaults for the top-level parameters
  localparam int GFBA_STACK_DEPTH  = 16;
  localparam int GFBA_TOTAL_BLOCKS = 1023;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_BLOCK_ZERO = 2'd2,
    ST_ALL_FREE   = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [BLK_W-1:0]  block_number;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0]  allocated_block;
    status_t           status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SPILL,
    S_FILL,
    S_RESP
  } state_t;

  // Decode of the current item, sampled by the sequencer in S_EXEC
  typedef struct packed {
    logic spill;
    logic fill;
  } dec_t;

  // Sequencer strobes to the datapath
  typedef struct packed {
    logic idle;
    logic exec;
    logic spill;
    logic fill;
    logic last;
    logic resp;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gfba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gfba_agu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Group record address: base (block * depth) latched once, then base + index.
module gfba_agu import gfba_pkg::*; #(
  parameter int STACK_DEPTH = GFBA_STACK_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                load,
  input  wire logic [BLK_W-1:0]                    src_blk,
  input  wire logic [$clog2(STACK_DEPTH+1)-1:0]    cnt,
  output logic      [BLK_W+$clog2(STACK_DEPTH)-1:0] addr
);

  localparam int TOP_W  = $clog2(STACK_DEPTH);
  localparam int ADDR_W = BLK_W + TOP_W;

  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] base_nxt;
  logic [ADDR_W-1:0] src_ext;

  assign src_ext  = ADDR_W'(src_blk);
  assign base_nxt = load ? src_ext * ADDR_W'(STACK_DEPTH) : base_r;

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
  end

  assign addr = base_r + ADDR_W'(cnt);

endmodule

`default_nettype wire

// ----- hw/rtl/gfba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gfba_ctrl import gfba_pkg::*; #(
  parameter int STACK_DEPTH = GFBA_STACK_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire dec_t                             dec,
  input  wire logic                             out_free,
  output ctl_t                                  ctl,
  output logic [$clog2(STACK_DEPTH+1)-1:0]      cnt
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               last;

  assign last = ((state_r == S_SPILL) && (cnt_r == CNT_W'(STACK_DEPTH - 1))) ||
                ((state_r == S_FILL)  && (cnt_r == CNT_W'(STACK_DEPTH)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (dec.spill)      state_nxt = S_SPILL;
        else if (dec.fill)  state_nxt = S_FILL;
        else                state_nxt = S_RESP;
      end
      S_SPILL, S_FILL: begin
        if (last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    if (((state_r == S_SPILL) || (state_r == S_FILL)) && !last) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    ctl       = '0;
    ctl.idle  = (state_r == S_IDLE);
    ctl.exec  = (state_r == S_EXEC);
    ctl.spill = (state_r == S_SPILL);
    ctl.fill  = (state_r == S_FILL);
    ctl.resp  = (state_r == S_RESP);
    ctl.last  = last;
  end

  assign cnt = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/grouped_free_block_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Grouped free-block allocator (classic grouped free list).
// Input channel in_valid/in_stall/in_item: opcode OP_ALLOC hands out a block,
// OP_FREE returns in_item.block_number. Each input transfer yields exactly one
// transfer on out_valid/out_stall/out_item (allocated_block, status).
// One item is in work at a time; in_stall is high from the input transfer
// until the result is loaded into the output register.
// Steps: a plain push/pop or rejected item goes S_EXEC then S_RESP; a free
// that spills a full stack goes S_EXEC, S_SPILL, S_RESP; an allocate that
// refills the stack goes S_EXEC, S_FILL, S_RESP.
// The spill and refill move one group-store word per cycle through the
// shared address unit (base + index).
// The output register lets the next item enter while a result waits; if the
// receiver stalls, a second result waits in S_RESP until the register frees.
// Reset clears the free count, stack top, stack entries and the sequencer.
// The group stores are not cleared: a refill from a never-written record
// returns whatever the memory holds.
module grouped_free_block_allocator import gfba_pkg::*; #(
  parameter int STACK_DEPTH  = GFBA_STACK_DEPTH,
  parameter int TOTAL_BLOCKS = GFBA_TOTAL_BLOCKS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int TOP_W    = $clog2(STACK_DEPTH);
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int FREE_W   = $clog2(TOTAL_BLOCKS + 1);
  localparam int ADDR_W   = BLK_W + TOP_W;
  localparam int GS_DEPTH = BLK_IDS * STACK_DEPTH;

  localparam logic [TOP_W-1:0]  TOP_MAX  = TOP_W'(STACK_DEPTH - 1);
  localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(TOTAL_BLOCKS);

  // Item latched at the input transfer
  opcode_t            op_r;
  logic [BLK_W-1:0]   blk_r;

  // Allocator state
  logic [TOP_W-1:0]   top_r,   top_nxt;
  logic [FREE_W-1:0]  free_r,  free_nxt;
  logic [BLK_W-1:0]   stack_r   [STACK_DEPTH];
  logic [BLK_W-1:0]   stack_nxt [STACK_DEPTH];

  // Pending result and output register
  logic [BLK_W-1:0]   res_blk_r, res_blk_nxt;
  status_t            res_st_r,  res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r,  out_item_nxt;

  ctl_t               ctl;
  dec_t               dec;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_m1;
  logic [TOP_W-1:0]   idx;
  logic [TOP_W-1:0]   fill_idx;
  logic [TOP_W-1:0]   rd_idx;
  logic [TOP_W-1:0]   top_inc;
  logic [BLK_W-1:0]   stack_rd;
  logic [BLK_W-1:0]   rec_blk;
  logic [BLK_W-1:0]   agu_src;
  logic [ADDR_W-1:0]  gs_addr;
  logic [BLK_W-1:0]   gs_rdata;
  logic [TOP_W-1:0]   gt_rdata;
  logic [TOP_W-1:0]   gt_sat;
  logic               out_load;
  logic               top_zero;
  logic               free_zero;

  assign in_stall = !ctl.idle;

  // --- decode for the sequencer -------------------------------------------
  assign top_zero  = (top_r == '0);
  assign free_zero = (free_r == '0);
  assign dec = '{
    spill: (op_r == OP_FREE) && (blk_r != '0) && (free_r != FREE_MAX) &&
           (top_r == TOP_MAX),
    fill:  (op_r == OP_ALLOC) && !free_zero && top_zero
  };

  gfba_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .dec      (dec),
    .out_free (out_load),
    .ctl      (ctl),
    .cnt      (cnt)
  );

  // --- stack read port: spill walks the index, pop reads the top ----------
  assign idx      = cnt[TOP_W-1:0];
  assign cnt_m1   = cnt - CNT_W'(1);
  assign fill_idx = cnt_m1[TOP_W-1:0];
  assign rd_idx   = ctl.spill ? idx : top_r;
  assign stack_rd = stack_r[rd_idx];
  assign rec_blk  = stack_r[0];
  assign top_inc  = top_r + TOP_W'(1);

  // Spill targets the freed block's record, refill the record in entry 0
  assign agu_src = (op_r == OP_FREE) ? blk_r : rec_blk;

  gfba_agu #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_agu (
    .clk     (clk),
    .load    (ctl.exec),
    .src_blk (agu_src),
    .cnt     (cnt),
    .addr    (gs_addr)
  );

  // Group record words: one stack entry per word
  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (GS_DEPTH)
  ) u_group_ram (
    .clk     (clk),
    .we      (ctl.spill),
    .waddr   (gs_addr),
    .wdata   (stack_rd),
    .re      (ctl.fill),
    .raddr   (gs_addr),
    .rdata_r (gs_rdata)
  );

  // Saved stack top per record; read once at S_EXEC, held until refill ends
  gfba_ram #(
    .WIDTH (TOP_W),
    .DEPTH (BLK_IDS)
  ) u_group_top_ram (
    .clk     (clk),
    .we      (ctl.spill && (cnt == '0)),
    .waddr   (blk_r),
    .wdata   (top_r),
    .re      (ctl.exec),
    .raddr   (rec_blk),
    .rdata_r (gt_rdata)
  );

  assign gt_sat = (gt_rdata > TOP_MAX) ? TOP_MAX : gt_rdata;

  // --- allocator state update ---------------------------------------------
  always_comb begin
    top_nxt     = top_r;
    free_nxt    = free_r;
    stack_nxt   = stack_r;
    res_blk_nxt = res_blk_r;
    res_st_nxt  = res_st_r;

    if (ctl.exec) begin
      unique case (op_r)
        OP_ALLOC: begin
          if (free_zero) begin
            res_blk_nxt = '0;
            res_st_nxt  = ST_NO_FREE;
          end else begin
            free_nxt   = free_r - FREE_W'(1);
            res_st_nxt = ST_OK;
            if (top_zero) begin
              // entry 0 goes out; its record refills the stack
              res_blk_nxt = rec_blk;
            end else begin
              res_blk_nxt       = stack_rd;
              stack_nxt[top_r]  = '0;
              top_nxt           = top_r - TOP_W'(1);
            end
          end
        end
        OP_FREE: begin
          res_blk_nxt = '0;
          if (blk_r == '0) begin
            res_st_nxt = ST_BLOCK_ZERO;
          end else if (free_r == FREE_MAX) begin
            res_st_nxt = ST_ALL_FREE;
          end else begin
            res_st_nxt = ST_OK;
            free_nxt   = free_r + FREE_W'(1);
            if (top_r != TOP_MAX) begin
              top_nxt            = top_inc;
              stack_nxt[top_inc] = blk_r;
            end
          end
        end
        default: ;
      endcase
    end

    // spill done: stack restarts with the freed block
    if (ctl.spill && ctl.last) begin
      top_nxt      = '0;
      stack_nxt[0] = blk_r;
    end

    // refill: read data comes from the registered RAM output, so it fills entry cnt - 1
    if (ctl.fill && (cnt != '0)) begin
      stack_nxt[fill_idx] = gs_rdata;
    end
    if (ctl.fill && ctl.last) begin
      top_nxt = gt_sat;
    end
  end

  // --- output register ----------------------------------------------------
  assign out_load = ctl.resp && (!out_valid_r || !out_stall);

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_item_nxt.allocated_block = res_blk_r;
      out_item_nxt.status          = res_st_r;
      out_valid_nxt                = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --- registers ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.idle && in_valid) begin
      op_r  <= in_item.opcode;
      blk_r <= in_item.block_number;
    end
    res_blk_r  <= res_blk_nxt;
    res_st_r   <= res_st_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_r[i] <= '0;
      end
    end else begin
      top_r       <= top_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      stack_r     <= stack_nxt;
    end
  end

  // --- assertions ---------------------------------------------------------
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_MAX)
    else $error("stack top beyond stack depth");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_MAX)
    else $error("free count beyond total blocks");

  a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> (free_r == $past(free_r)) ||
                 (free_r == $past(free_r) + FREE_W'(1)) ||
                 (free_r == $past(free_r) - FREE_W'(1)))
    else $error("free count moved by more than one");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.resp))
    else $error("result shown without a finished item");

  a_long_op_idle_input: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.spill || ctl.fill) |-> in_stall && !out_load)
    else $error("input taken or result loaded during spill or refill");

endmodule

`default_nettype wire
